@@ rtl/hyperloglog_sketch_update_unit_defines.svh @@
// Assertion macros shared by the sketch update unit.
`ifndef HYPERLOGLOG_SKETCH_UPDATE_UNIT_DEFINES_SVH
`define HYPERLOGLOG_SKETCH_UPDATE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define HLLSU_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define HLLSU_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define HLLSU_ASSERT_IMP(name, clk, rst_n, ante, cons, msg)
`define HLLSU_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ rtl/hllsu_pkg.sv @@
// Shared types, constants and helper functions of the sketch update unit.
`timescale 1ns / 1ps
`default_nettype none
package hllsu_pkg;

  localparam int PRECISION_BITS_DEF = 14;
  localparam int FRACTION_BITS_DEF  = 40;

  localparam int HASH_W   = 64;
  localparam int SHIFT_W  = 8;
  localparam int MIDX_W   = 14;
  localparam int VAL_W    = 8;
  localparam int BUCKET_W = 14;
  localparam int SUM_W    = 56;
  localparam int ZC_W     = 15;
  localparam int RANK_W   = 7;
  localparam int CNT_W    = 6;
  localparam int CAND_W   = 10;
  localparam int RANK_ZERO_SUFFIX = 64;

  typedef enum logic [1:0] {
    REQ_INSERT  = 2'd0,
    REQ_MERGE   = 2'd1,
    REQ_CLEAR   = 2'd2,
    REQ_SUMMARY = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RANK,
    ST_UPD,
    ST_SUM,
    ST_DONE
  } state_t;

  // Leading zeros of a byte; only meaningful for a non-zero byte.
  function automatic logic [2:0] lead_zero8(input logic [7:0] v);
    logic [2:0] n;
    logic       found;
    n     = '0;
    found = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (!found) begin
        if (v[i]) begin
          found = 1'b1;
        end else begin
          n = n + 3'd1;
        end
      end
    end
    return n;
  endfunction

endpackage
`default_nettype wire

@@ rtl/hllsu_ram.sv @@
// Sketch register memory: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module hllsu_ram
  import hllsu_pkg::*;
#(
  parameter int ADDR_W = PRECISION_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [VAL_W-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [VAL_W-1:0]  rd_data
);

  logic [VAL_W-1:0] mem [2**ADDR_W];
  logic [VAL_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

@@ rtl/hllsu_lzc.sv @@
// Iterative rank unit: counts leading zeros of the hash suffix a byte per cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "hyperloglog_sketch_update_unit_defines.svh"
module hllsu_lzc
  import hllsu_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [HASH_W-1:0] suffix,
  output logic                   done,
  output logic      [RANK_W-1:0] rank
);

  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(HASH_W - 8);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [HASH_W-1:0] sh_r, sh_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [RANK_W-1:0] rank_r, rank_nxt;
  logic [7:0]        top_byte;

  assign top_byte = sh_r[HASH_W-1 -: 8];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r   <= sh_nxt;
    cnt_r  <= cnt_nxt;
    rank_r <= rank_nxt;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sh_nxt   = sh_r;
    cnt_nxt  = cnt_r;
    rank_nxt = rank_r;
    if (start) begin
      busy_nxt = 1'b1;
      sh_nxt   = suffix;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      if (top_byte != 8'd0) begin
        rank_nxt = {1'b0, cnt_r} + RANK_W'(lead_zero8(top_byte)) + RANK_W'(1);
        done_nxt = 1'b1;
        busy_nxt = 1'b0;
      end else if (cnt_r == LAST_CNT) begin
        // An all-zero suffix ranks as the full word width.
        rank_nxt = RANK_W'(RANK_ZERO_SUFFIX);
        done_nxt = 1'b1;
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r + CNT_W'(8);
        sh_nxt  = sh_r << 8;
      end
    end
  end

  assign done = done_r;
  assign rank = rank_r;

  `HLLSU_ASSERT_IMP(a_done_after_busy, clk, rst_n, done_r, $past(busy_r), "rank done without a busy step")
  `HLLSU_ASSERT_IMP(a_rank_range, clk, rst_n, done_r, rank_r != '0 && rank_r <= RANK_W'(RANK_ZERO_SUFFIX), "rank outside 1 to 64")

endmodule
`default_nettype wire

@@ rtl/hllsu_acc.sv @@
// Summary accumulator: saturating sum of 2^-r and count of zero registers.
`timescale 1ns / 1ps
`default_nettype none
module hllsu_acc
  import hllsu_pkg::*;
#(
  parameter int FRAC_BITS = FRACTION_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             clr,
  input  wire logic             en,
  input  wire logic [VAL_W-1:0] reg_val,
  output logic      [SUM_W-1:0] sum,
  output logic      [ZC_W-1:0]  zero_count
);

  localparam logic [VAL_W-1:0] FRAC_V = VAL_W'(FRAC_BITS);

  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [ZC_W-1:0]  zc_r, zc_nxt;
  logic [SUM_W-1:0] term;
  logic [SUM_W:0]   sum_ext;

  // Terms below the fixed-point resolution drop to zero.
  assign term    = (reg_val <= FRAC_V) ? (SUM_W'(1) << (FRAC_V - reg_val)) : '0;
  assign sum_ext = {1'b0, sum_r} + {1'b0, term};

  always_comb begin
    sum_nxt = sum_r;
    zc_nxt  = zc_r;
    if (clr) begin
      sum_nxt = '0;
      zc_nxt  = '0;
    end else if (en) begin
      sum_nxt = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
      if (reg_val == '0 && zc_r != '1) begin
        zc_nxt = zc_r + ZC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
    zc_r  <= zc_nxt;
  end

  assign sum        = sum_r;
  assign zero_count = zc_r;

endmodule
`default_nettype wire

@@ rtl/hyperloglog_sketch_update_unit.sv @@
// Top level of the sketch update unit: request sequencer, memory and datapath.
`timescale 1ns / 1ps
`default_nettype none
`include "hyperloglog_sketch_update_unit_defines.svh"
// One request is taken at a time; in_stall stays high until its result has been
// loaded into the output register, which may still be waiting for the consumer
// when the next request arrives. A merge passes through the update and done states;
// an insert first waits in the rank state for the rank unit, which scans the hash
// suffix one byte per cycle. Clear and summarize sweep the sketch memory through its
// single write or read port, one register per cycle. After reset the memory is
// cleared in a pass over all 2^PRECISION_BITS registers, during which no request
// is taken.
module hyperloglog_sketch_update_unit
  import hllsu_pkg::*;
#(
  parameter int PRECISION_BITS = PRECISION_BITS_DEF,
  parameter int FRACTION_BITS  = FRACTION_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          in_req_type,
  input  wire logic [HASH_W-1:0]   in_hash,
  input  wire logic [SHIFT_W-1:0]  in_shift,
  input  wire logic [MIDX_W-1:0]   in_merge_index,
  input  wire logic [VAL_W-1:0]    in_merge_value,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic      [BUCKET_W-1:0] out_bucket,
  output logic                     out_raised,
  output logic      [SUM_W-1:0]    out_harmonic_sum,
  output logic      [ZC_W-1:0]     out_zero_count
);

  localparam int P = PRECISION_BITS;
  localparam logic [P:0] LAST_ADDR = (P+1)'((1 << P) - 1);

  state_t             state_r, state_nxt;
  req_t               req_r, req_nxt;
  logic [P:0]         addr_r, addr_nxt;
  logic               rd_pend_r, rd_pend_nxt;
  logic               clr_owed_r, clr_owed_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [P-1:0]       idx_r, idx_nxt;
  logic [SHIFT_W-1:0] shift_r, shift_nxt;
  logic [VAL_W-1:0]   mval_r, mval_nxt;
  logic               raised_r, raised_nxt;
  logic [BUCKET_W-1:0] out_bucket_r, out_bucket_nxt;
  logic               out_raised_r, out_raised_nxt;
  logic [SUM_W-1:0]   out_sum_r, out_sum_nxt;
  logic [ZC_W-1:0]    out_zc_r, out_zc_nxt;

  logic               in_accept;
  req_t               req_in;
  logic [P-1:0]       hash_idx;
  logic [P+MIDX_W-1:0] midx_ext;
  logic [P+BUCKET_W-1:0] bkt_ext;

  logic               ram_wr_en;
  logic [P-1:0]       ram_wr_addr;
  logic [VAL_W-1:0]   ram_wr_data;
  logic               ram_rd_en;
  logic [P-1:0]       ram_rd_addr;
  logic [VAL_W-1:0]   ram_rd_data;

  logic               lzc_start;
  logic               lzc_done;
  logic [RANK_W-1:0]  lzc_rank;
  logic [HASH_W-1:0]  suffix;

  logic               acc_clr;
  logic [SUM_W-1:0]   acc_sum;
  logic [ZC_W-1:0]    acc_zc;

  logic [CAND_W-1:0]  cand;
  logic               raise;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign req_in    = req_t'(in_req_type);
  assign hash_idx  = in_hash[HASH_W-1 -: P];
  assign suffix    = in_hash << P;
  assign midx_ext  = (P+MIDX_W)'(in_merge_index);
  assign bkt_ext   = (P+BUCKET_W)'(idx_r);

  // Candidate value: rank plus signed shift for an insert, the other sketch's
  // value for a merge. Anything negative never raises a register.
  assign cand  = (req_r == REQ_INSERT)
               ? ({3'b000, lzc_rank} + {{(CAND_W-SHIFT_W){shift_r[SHIFT_W-1]}}, shift_r})
               : {2'b00, mval_r};
  assign raise = !cand[CAND_W-1] && (cand[CAND_W-2:0] > {1'b0, ram_rd_data});

  hllsu_ram #(
    .ADDR_W (P)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  hllsu_lzc u_lzc (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (lzc_start),
    .suffix (suffix),
    .done   (lzc_done),
    .rank   (lzc_rank)
  );

  hllsu_acc #(
    .FRAC_BITS (FRACTION_BITS)
  ) u_acc (
    .clk        (clk),
    .clr        (acc_clr),
    .en         (rd_pend_r),
    .reg_val    (ram_rd_data),
    .sum        (acc_sum),
    .zero_count (acc_zc)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      addr_r      <= '0;
      rd_pend_r   <= 1'b0;
      clr_owed_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      rd_pend_r   <= rd_pend_nxt;
      clr_owed_r  <= clr_owed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    idx_r        <= idx_nxt;
    shift_r      <= shift_nxt;
    mval_r       <= mval_nxt;
    raised_r     <= raised_nxt;
    out_bucket_r <= out_bucket_nxt;
    out_raised_r <= out_raised_nxt;
    out_sum_r    <= out_sum_nxt;
    out_zc_r     <= out_zc_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    addr_nxt       = addr_r;
    rd_pend_nxt    = 1'b0;
    clr_owed_nxt   = clr_owed_r;
    out_valid_nxt  = out_valid_r;
    idx_nxt        = idx_r;
    shift_nxt      = shift_r;
    mval_nxt       = mval_r;
    raised_nxt     = raised_r;
    out_bucket_nxt = out_bucket_r;
    out_raised_nxt = out_raised_r;
    out_sum_nxt    = out_sum_r;
    out_zc_nxt     = out_zc_r;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = idx_r;
    ram_wr_data    = cand[VAL_W-1:0];
    ram_rd_en      = 1'b0;
    ram_rd_addr    = addr_r[P-1:0];
    lzc_start      = 1'b0;
    acc_clr        = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = addr_r[P-1:0];
        ram_wr_data = '0;
        addr_nxt    = addr_r + (P+1)'(1);
        if (addr_r == LAST_ADDR) begin
          addr_nxt     = '0;
          clr_owed_nxt = 1'b0;
          // The pass after reset owes no result; a clear request does.
          state_nxt    = clr_owed_r ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          req_nxt   = req_in;
          shift_nxt = in_shift;
          mval_nxt  = in_merge_value;
          case (req_in)
            REQ_INSERT: begin
              idx_nxt     = hash_idx;
              ram_rd_en   = 1'b1;
              ram_rd_addr = hash_idx;
              lzc_start   = 1'b1;
              state_nxt   = ST_RANK;
            end
            REQ_MERGE: begin
              idx_nxt     = midx_ext[P-1:0];
              ram_rd_en   = 1'b1;
              ram_rd_addr = midx_ext[P-1:0];
              state_nxt   = ST_UPD;
            end
            REQ_CLEAR: begin
              addr_nxt     = '0;
              clr_owed_nxt = 1'b1;
              state_nxt    = ST_CLEAR;
            end
            REQ_SUMMARY: begin
              addr_nxt  = '0;
              acc_clr   = 1'b1;
              state_nxt = ST_SUM;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_RANK: begin
        if (lzc_done) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        ram_wr_en  = raise;
        raised_nxt = raise;
        state_nxt  = ST_DONE;
      end
      ST_SUM: begin
        // One read a cycle; the accumulator takes each word in the cycle after its read.
        if (!addr_r[P]) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = addr_r[P-1:0];
          addr_nxt    = addr_r + (P+1)'(1);
          rd_pend_nxt = 1'b1;
        end else if (!rd_pend_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (req_r == REQ_INSERT || req_r == REQ_MERGE) begin
            out_bucket_nxt = bkt_ext[BUCKET_W-1:0];
            out_raised_nxt = raised_r;
            out_sum_nxt    = '0;
            out_zc_nxt     = '0;
          end else begin
            out_bucket_nxt = '0;
            out_raised_nxt = 1'b0;
            out_sum_nxt    = (req_r == REQ_SUMMARY) ? acc_sum : '0;
            out_zc_nxt     = (req_r == REQ_SUMMARY) ? acc_zc : '0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_bucket       = out_bucket_r;
  assign out_raised       = out_raised_r;
  assign out_harmonic_sum = out_sum_r;
  assign out_zero_count   = out_zc_r;

  `HLLSU_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_accept, in_stall, "request accepted but unit not busy next cycle")
  `HLLSU_ASSERT_IMP(a_write_raises, clk, rst_n, ram_wr_en && state_r == ST_UPD, ram_wr_data > ram_rd_data, "sketch register written without a raise")
  `HLLSU_ASSERT_IMP(a_raise_no_summary, clk, rst_n, out_valid_r && out_raised_r, out_sum_r == '0 && out_zc_r == '0, "raised result carries summary fields")
  `HLLSU_ASSERT_IMP(a_rank_in_rank_state, clk, rst_n, lzc_done, state_r == ST_RANK, "rank finished outside an insert")

endmodule
`default_nettype wire
